@@ rtl/srld_pkg.sv @@
`default_nettype none

package srld_pkg;

	// Field widths
	localparam int MicW     = 10;
	localparam int TimeW    = 32;
	localparam int DutyW    = 8;
	localparam int ThreshW  = 9;
	localparam int MciW     = 7;
	localparam int DimIntW  = 10;
	localparam int CfgDataW = 10;
	localparam int CfgIdxW  = 2;
	localparam int LfsrW    = 16;

	// Level arithmetic
	localparam int AmplitudeMax = 500;
	localparam int AdcMax       = 1023;
	localparam int PwmMax       = 255;
	// floor(t / 500) = (t * RecipLevel) >> RecipShift for t up to 255 * 500
	localparam int RecipLevel   = 134218;
	localparam int RecipShift   = 26;

	localparam logic [DutyW-1:0] DimStep  = 8'd10;
	localparam logic [LfsrW-1:0] LfsrTaps = 16'hB400;
	localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;

	// Register reset values
	localparam logic [ThreshW-1:0] ThreshLowRst  = 9'd100;
	localparam logic [ThreshW-1:0] ThreshHighRst = 9'd250;
	localparam logic [MciW-1:0]    MciRst        = 7'd50;
	localparam logic [DimIntW-1:0] DimIntRst     = 10'd100;

	typedef enum logic [CfgIdxW-1:0] {
		REG_THRESHOLD_LOW       = 2'd0,
		REG_THRESHOLD_HIGH      = 2'd1,
		REG_MIN_CHANGE_INTERVAL = 2'd2,
		REG_DIMMING_INTERVAL    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [MicW-1:0]  mic_sample;
		logic [TimeW-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [DutyW-1:0] red_duty;
		logic [DutyW-1:0] green_duty;
		logic [DutyW-1:0] blue_duty;
		logic             beat_indicator;
	} out_item_t;

	typedef struct packed {
		logic [ThreshW-1:0] threshold_low;
		logic [ThreshW-1:0] threshold_high;
		logic [MciW-1:0]    min_change_interval;
		logic [DimIntW-1:0] dimming_interval;
	} srld_cfg_t;

	// Sample after level conversion
	typedef struct packed {
		logic [ThreshW-1:0] raw;
		logic [DutyW-1:0]   level;
		logic [TimeW-1:0]   now_ms;
	} lvl_t;

	function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] v);
		logic [LfsrW-1:0] n;
		n = v >> 1;
		if (v[0]) begin
			n = n ^ LfsrTaps;
		end
		return n;
	endfunction

	// floor(c * s / 255): estimate by >> 8, then one correction step
	function automatic logic [DutyW-1:0] scale_color(input logic [DutyW-1:0] c,
							  input logic [DutyW-1:0] s);
		logic [15:0] p;
		logic [7:0]  q0;
		logic [15:0] back;
		logic [15:0] r;
		p    = {8'd0, c} * {8'd0, s};
		q0   = p[15:8];
		back = {q0, 8'd0} - {8'd0, q0};
		r    = p - back;
		return (r >= 16'd255) ? (q0 + 8'd1) : q0;
	endfunction

	// (lfsr * level) >> 16
	function automatic logic [DutyW-1:0] beat_color(input logic [LfsrW-1:0] l,
							 input logic [DutyW-1:0] lv);
		logic [23:0] p;
		p = {8'd0, l} * {16'd0, lv};
		return p[23:16];
	endfunction

endpackage

`default_nettype wire

@@ rtl/srld_cfg.sv @@
`default_nettype none

module srld_cfg
	import srld_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output srld_cfg_t                cfg
);

	srld_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_low       <= ThreshLowRst;
			cfg_q.threshold_high      <= ThreshHighRst;
			cfg_q.min_change_interval <= MciRst;
			cfg_q.dimming_interval    <= DimIntRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD_LOW:       cfg_q.threshold_low       <= cfg_data[ThreshW-1:0];
				REG_THRESHOLD_HIGH:      cfg_q.threshold_high      <= cfg_data[ThreshW-1:0];
				REG_MIN_CHANGE_INTERVAL: cfg_q.min_change_interval <= cfg_data[MciW-1:0];
				REG_DIMMING_INTERVAL:    cfg_q.dimming_interval    <= cfg_data[DimIntW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/srld_level.sv @@
`default_nettype none

module srld_level
	import srld_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_data,
	input  wire logic     ready_s1,
	output logic          valid_s1,
	output lvl_t          lvl_s1
);

	logic [19:0] p;
	logic [9:0]  q0;
	logic [19:0] back;
	logic [19:0] r;
	logic [9:0]  q;
	logic [9:0]  dev;
	logic [8:0]  raw;
	logic [16:0] t;
	logic [34:0] prod;
	lvl_t        lvl_d;
	logic        take;

	// q = x * 1000 / 1023: estimate by >> 10, off by at most one
	always_comb begin
		p    = ({10'd0, in_data.mic_sample} << 10) - ({10'd0, in_data.mic_sample} << 4)
		     - ({10'd0, in_data.mic_sample} << 3);
		q0   = p[19:10];
		back = {q0, 10'd0} - {10'd0, q0};
		r    = p - back;
		q    = (r >= 20'(AdcMax)) ? (q0 + 10'd1) : q0;
		dev  = (q >= 10'(AmplitudeMax)) ? (q - 10'(AmplitudeMax)) : (10'(AmplitudeMax) - q);
		raw  = (dev > 10'(AmplitudeMax)) ? 9'(AmplitudeMax) : dev[8:0];
		t    = ({raw, 8'd0}) - {8'd0, raw};
		prod = {18'd0, t} * 35'(RecipLevel);
		lvl_d.raw    = raw;
		lvl_d.level  = prod[RecipShift+7:RecipShift];
		lvl_d.now_ms = in_data.now_ms;
	end

	assign in_stall = valid_s1 && !ready_s1;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lvl_s1 <= lvl_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/srld_core.sv @@
`default_nettype none

module srld_core
	import srld_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire srld_cfg_t cfg,
	input  wire logic      valid_s1,
	input  wire lvl_t      lvl_s1,
	output logic           ready_s1,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	logic             first_beat_q;
	logic [TimeW-1:0] last_change_q;
	logic [TimeW-1:0] last_act_q;
	logic             dimming_q;
	logic [DutyW-1:0] color_q [3];
	logic [DutyW-1:0] dim_q;
	logic             ind_q;
	logic [LfsrW-1:0] lfsr_q;

	logic             out_valid_q;
	out_item_t        out_data_q;

	logic [ThreshW-1:0] high_eff;
	logic               active;
	logic               beat;
	logic               change_ok;
	logic [TimeW-1:0]   since_change;
	logic [TimeW-1:0]   since_act;
	logic [12:0]        wait_ms;
	logic               dim_ok;
	logic [DutyW-1:0]   dim_next;
	logic [LfsrW-1:0]   l1, l2, l3;
	logic [DutyW-1:0]   new_color [3];
	logic [DutyW-1:0]   scale;
	logic [DutyW-1:0]   scaled [3];
	logic               draw;
	logic               emit;
	out_item_t          res;
	logic               adv;

	always_comb begin
		high_eff = (cfg.threshold_high > cfg.threshold_low) ? cfg.threshold_high
								    : cfg.threshold_low;
		active   = lvl_s1.raw > cfg.threshold_low;
		beat     = active && (lvl_s1.raw >= high_eff);

		since_change = lvl_s1.now_ms - last_change_q;
		change_ok    = !first_beat_q || (since_change >= {25'd0, cfg.min_change_interval});
		draw         = beat && change_ok;

		since_act = lvl_s1.now_ms - last_act_q;
		wait_ms   = dimming_q ? {3'd0, cfg.dimming_interval}
				      : ({3'd0, cfg.dimming_interval} << 2) + {3'd0, cfg.dimming_interval};
		dim_ok    = !active && (dim_q != '0) && (since_act > {19'd0, wait_ms});
		dim_next  = (dim_q > DimStep) ? (dim_q - DimStep) : '0;

		l1 = lfsr_next(lfsr_q);
		l2 = lfsr_next(l1);
		l3 = lfsr_next(l2);
		new_color[0] = beat_color(l1, lvl_s1.level);
		new_color[1] = beat_color(l2, lvl_s1.level);
		new_color[2] = beat_color(l3, lvl_s1.level);

		scale = active ? lvl_s1.level : dim_next;
		for (int i = 0; i < 3; i++) begin
			scaled[i] = scale_color(color_q[i], scale);
		end

		emit = draw || (active && !beat) || dim_ok;

		if (draw) begin
			res.red_duty       = new_color[0];
			res.green_duty     = new_color[1];
			res.blue_duty      = new_color[2];
			res.beat_indicator = 1'b1;
		end else begin
			res.red_duty       = scaled[0];
			res.green_duty     = scaled[1];
			res.blue_duty      = scaled[2];
			// a dim step repeats the last indicator value
			res.beat_indicator = active ? 1'b0 : ind_q;
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign ready_s1 = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_beat_q  <= 1'b0;
			last_change_q <= '0;
			last_act_q    <= '0;
			dimming_q     <= 1'b0;
			color_q[0]    <= '0;
			color_q[1]    <= '0;
			color_q[2]    <= '0;
			dim_q         <= '0;
			ind_q         <= 1'b0;
			lfsr_q        <= LfsrSeed;
			out_valid_q   <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				if (draw) begin
					color_q[0]    <= new_color[0];
					color_q[1]    <= new_color[1];
					color_q[2]    <= new_color[2];
					lfsr_q        <= l3;
					last_change_q <= lvl_s1.now_ms;
					first_beat_q  <= 1'b1;
					ind_q         <= 1'b1;
				end else if (active && !beat) begin
					ind_q <= 1'b0;
				end
				if (active) begin
					dim_q     <= lvl_s1.level;
					dimming_q <= 1'b0;
				end else if (dim_ok) begin
					dim_q     <= dim_next;
					dimming_q <= 1'b1;
				end
				if (emit) begin
					last_act_q <= lvl_s1.now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/sound_reactive_rgb_led_driver_core.sv @@
// An accepted request's level is registered in s1, then its result in the output register.
// Throughput: one request per cycle while no held output result is stalled by out_stall.
// A request that leaves no result still takes its turn through the state stage.
// Reset (arst_n, asynchronous, low): registers to defaults, colours and timers to zero,
// LFSR to its seed; no result pending.
`default_nettype none

module sound_reactive_rgb_led_driver_core
	import srld_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_item_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_item_t                out_data,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	srld_cfg_t cfg;
	logic      valid_s1;
	logic      ready_s1;
	lvl_t      lvl_s1;

	// Register file: thresholds and intervals; write only while idle (the block does not enforce this)
	srld_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: sample to centred amplitude (raw) and 0..255 level, no state involved
	srld_level u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.ready_s1 (ready_s1),
		.valid_s1 (valid_s1),
		.lvl_s1   (lvl_s1)
	);

	// Stage 2: beat / medium / silence decision, colour store, LFSR, dimming
	// timers and the output register. Stage 1 stalls only while a result is
	// held on the output and not taken.
	srld_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.lvl_s1    (lvl_s1),
		.ready_s1  (ready_s1),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// A new result only ever comes from a request held in stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a request in stage 1");

	// Stage 1 holds its request while the state stage cannot advance
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s1) |=> (valid_s1 && $stable(lvl_s1)))
		else $error("stage 1 request lost under stall");

	// The centred amplitude never exceeds full scale
	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (lvl_s1.raw <= 9'(AmplitudeMax)))
		else $error("amplitude out of range");
`endif

endmodule

`default_nettype wire
